// ----- sv/spr_pkg.sv -----
// Shared constants and codes for the shortest-path relaxation block.
package spr_pkg;

	// Default sizing
	localparam int MAX_NODES_DEF  = 64;
	localparam int COST_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 8;

	// Fixed field widths on the ports
	localparam int NODE_W   = 6;
	localparam int WEIGHT_W = 32;
	localparam int CFG_W    = 7;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 8;

	// Configuration register indexes
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_SWAP_THR   = 1'b1;

	// Request kinds carried in tuser
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;
	localparam logic [5:0]       SWAP_THR_RST   = 6'd63;

endpackage

// ----- sv/shortest_path_relaxation.sv -----
// Sequence: a weight write beat is stored directly; a query runs a setup pass over the
// source row, then relaxation (each target in turn), one edge per cycle through the weight
// memory read port, then walks the predecessors back and sends the path beats.
// Throughput: weight writes one beat per cycle while idle; queries one at a time.
// Reset: arst_n clears control state and loads the configuration defaults; memories are not cleared.
// Top level: shortest-path query engine over an edge-cost memory.
module shortest_path_relaxation #(
	parameter int MAX_NODES  = spr_pkg::MAX_NODES_DEF,
	parameter int COST_WIDTH = spr_pkg::COST_WIDTH_DEF,
	parameter int FRAC_BITS  = spr_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config port
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [spr_pkg::CFG_W-1:0]     cfg_wdata,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// row[5:0], col[11:6], weight[43:12], src_node[49:44], dst_node[55:50]
	input  logic [spr_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                          s_tuser,
	// path stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// path_node[5:0], zero pad [7:6]
	output logic [spr_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);

	localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int DW   = $clog2(MAX_NODES + 1);
	localparam int AW   = 2 * NW;
	localparam int CW   = COST_WIDTH;
	localparam int WW   = (CW > spr_pkg::WEIGHT_W) ? CW : spr_pkg::WEIGHT_W;
	// costs carry FRAC_BITS fraction bits; only add and compare occur
	localparam int FB   = FRAC_BITS;
	localparam logic [CW-1:0] COST_MAX = {CW{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_INIT_DR, ST_LOAD, ST_LATCH, ST_SWEEP, ST_DRAIN,
		ST_PUSH, ST_CHK, ST_ERD, ST_ELD, ST_EWAIT
	} state_t;

	state_t state_q;

	// configuration
	logic [spr_pkg::CFG_W-1:0] node_count_q;
	logic [5:0]                swap_thr_q;

	// request fields
	logic [5:0]          f_row, f_col, f_src, f_dst;
	logic [spr_pkg::WEIGHT_W-1:0] f_weight;
	assign f_row    = s_tdata[5:0];
	assign f_col    = s_tdata[11:6];
	assign f_weight = s_tdata[43:12];
	assign f_src    = s_tdata[49:44];
	assign f_dst    = s_tdata[55:50];

	logic s_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// query context
	logic [DW-1:0] n_q;
	logic [NW-1:0] src_q, dst_q;
	logic          tr_q;
	logic [NW-1:0] cnt_q;     // init index / sweep v
	logic [NW-1:0] i_q, m_q;
	logic          phase_q;   // 0: target i, 1: target m
	logic [CW-1:0] dist_t_q;
	logic [NW-1:0] x_q;
	logic [DW-1:0] depth_q, k_q;

	// pipeline stage after a memory read
	logic          init_s1, rel_s1;
	logic [NW-1:0] v_s1;

	// memory read data
	logic [CW-1:0]   w_rd_q, d_rd_q;
	logic [NW:0]     p_rd_q;
	logic [NW-1:0]   st_rd_q;

	logic [NW-1:0] last_node, t_node;
	assign last_node = NW'(n_q - DW'(1));
	assign t_node    = phase_q ? m_q : i_q;

	// effective node count, clamped
	logic [DW-1:0] n_eff;
	always_comb begin
		if (node_count_q < spr_pkg::CFG_W'(2))
			n_eff = DW'(2);
		else if (node_count_q > spr_pkg::CFG_W'(MAX_NODES))
			n_eff = DW'(MAX_NODES);
		else
			n_eff = DW'(node_count_q);
	end

	logic q_ok, q_swap;
	assign q_ok   = (7'(f_src) < 7'(n_eff)) && (7'(f_dst) < 7'(n_eff));
	assign q_swap = 8'(f_src) > (8'(f_dst) + 8'(swap_thr_q));

	// weight write with clamp to the cost range
	logic [WW-1:0] w_wide;
	logic [CW-1:0] w_clamped;
	logic          w_we;
	logic [AW-1:0] w_waddr, w_raddr;
	assign w_wide    = WW'(f_weight);
	assign w_clamped = (w_wide > WW'(COST_MAX)) ? COST_MAX : CW'(w_wide);
	assign w_we      = s_acc && (s_tuser == spr_pkg::REQ_WRITE)
		&& (7'(f_row) < 7'(MAX_NODES)) && (7'(f_col) < 7'(MAX_NODES));
	assign w_waddr   = {NW'(f_row), NW'(f_col)};

	// edge(from, to): init reads (src, cnt), sweep reads (v, t)
	logic [NW-1:0] e_from, e_to;
	always_comb begin
		if (state_q == ST_INIT) begin
			e_from = src_q;
			e_to   = cnt_q;
		end else begin
			e_from = cnt_q;
			e_to   = t_node;
		end
		w_raddr = tr_q ? {e_to, e_from} : {e_from, e_to};
	end

	// saturating relax of target t through v
	logic [CW-1:0] dv, cand;
	logic [CW:0]   sum;
	logic          improve;
	always_comb begin
		dv      = (v_s1 == t_node) ? dist_t_q : d_rd_q;
		sum     = {1'b0, dv} + {1'b0, w_rd_q};
		cand    = sum[CW] ? COST_MAX : sum[CW-1:0];
		improve = rel_s1 && (dist_t_q > cand);
	end

	// distance / predecessor write port
	logic          d_we;
	logic [NW-1:0] d_waddr, d_raddr;
	logic [CW-1:0] d_wdata;
	logic [NW:0]   p_wdata;
	always_comb begin
		d_we    = init_s1 || improve;
		d_waddr = init_s1 ? v_s1 : t_node;
		d_wdata = init_s1 ? w_rd_q : cand;
		p_wdata = init_s1 ? {1'b1, src_q} : {1'b0, v_s1};
		d_raddr = (state_q == ST_LOAD) ? t_node : cnt_q;
	end

	// path stack write port
	logic          st_we;
	logic [NW-1:0] st_waddr, st_raddr, st_wdata;
	logic [DW-1:0] e_idx;
	always_comb begin
		st_we    = (state_q == ST_PUSH)
			|| ((state_q == ST_CHK) && p_rd_q[NW] && (depth_q < DW'(MAX_NODES)));
		st_waddr = NW'(depth_q);
		st_wdata = (state_q == ST_PUSH) ? x_q : src_q;
		e_idx    = tr_q ? k_q : (depth_q - DW'(1) - k_q);
		st_raddr = NW'(e_idx);
	end

	// memories
	logic [CW-1:0] w_mem  [1 << AW];
	logic [CW-1:0] d_mem  [1 << NW];
	logic [NW:0]   p_mem  [1 << NW];
	logic [NW-1:0] st_mem [1 << NW];

	always_ff @(posedge clk) begin
		if (w_we)
			w_mem[w_waddr] <= w_clamped;
		w_rd_q <= w_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			d_mem[d_waddr] <= d_wdata;
			p_mem[d_waddr] <= p_wdata;
		end
		d_rd_q <= d_mem[d_raddr];
		p_rd_q <= p_mem[x_q];
	end

	always_ff @(posedge clk) begin
		if (st_we)
			st_mem[st_waddr] <= st_wdata;
		st_rd_q <= st_mem[st_raddr];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= spr_pkg::NODE_COUNT_RST;
			swap_thr_q   <= spr_pkg::SWAP_THR_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				spr_pkg::REG_NODE_COUNT: node_count_q <= cfg_wdata;
				spr_pkg::REG_SWAP_THR:   swap_thr_q   <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			init_s1  <= 1'b0;
			rel_s1   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			n_q      <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			tr_q     <= 1'b0;
			cnt_q    <= '0;
			i_q      <= '0;
			m_q      <= '0;
			phase_q  <= 1'b0;
			dist_t_q <= '0;
			x_q      <= '0;
			depth_q  <= '0;
			k_q      <= '0;
			v_s1     <= '0;
		end else begin
			init_s1 <= 1'b0;
			rel_s1  <= 1'b0;
			if (improve)
				dist_t_q <= cand;
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == spr_pkg::REQ_QUERY) && q_ok) begin
						n_q   <= n_eff;
						tr_q  <= q_swap;
						src_q <= q_swap ? NW'(f_dst) : NW'(f_src);
						dst_q <= q_swap ? NW'(f_src) : NW'(f_dst);
						cnt_q <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					init_s1 <= 1'b1;
					v_s1    <= cnt_q;
					cnt_q   <= cnt_q + NW'(1);
					if (cnt_q == last_node)
						state_q <= ST_INIT_DR;
				end
				ST_INIT_DR: begin
					i_q     <= NW'(1);
					m_q     <= '0;
					phase_q <= 1'b0;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					dist_t_q <= d_rd_q;
					state_q  <= ST_SWEEP;
				end
				ST_SWEEP: begin
					rel_s1 <= 1'b1;
					v_s1   <= cnt_q;
					cnt_q  <= cnt_q + NW'(1);
					if (cnt_q == last_node)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// pick the next target
					if (!phase_q) begin
						phase_q <= 1'b1;
						m_q     <= '0;
						state_q <= ST_LOAD;
					end else if (m_q + NW'(1) != i_q) begin
						m_q     <= m_q + NW'(1);
						state_q <= ST_LOAD;
					end else if (i_q != last_node) begin
						i_q     <= i_q + NW'(1);
						phase_q <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						x_q     <= dst_q;
						depth_q <= '0;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					depth_q <= depth_q + DW'(1);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!p_rd_q[NW] && (depth_q < DW'(MAX_NODES))) begin
						x_q     <= p_rd_q[NW-1:0];
						state_q <= ST_PUSH;
					end else begin
						if (p_rd_q[NW] && (depth_q < DW'(MAX_NODES)))
							depth_q <= depth_q + DW'(1);
						k_q     <= '0;
						state_q <= ST_ERD;
					end
				end
				ST_ERD: state_q <= ST_ELD;
				ST_ELD: begin
					m_tvalid <= 1'b1;
					m_tdata  <= spr_pkg::M_DATA_W'(st_rd_q);
					m_tlast  <= (k_q == depth_q - DW'(1));
					state_q  <= ST_EWAIT;
				end
				ST_EWAIT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + DW'(1);
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// fraction bits do not change the arithmetic; keep the check at elaboration
	if (FB > CW) begin : g_bad_frac
		$error("FRAC_BITS exceeds COST_WIDTH");
	end

endmodule

// ----- sv/spr_checker.sv -----
// Port-level checks for the shortest-path block, bound to the top level.
module spr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [spr_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         m_tlast
);

	// no new request is taken while a path beat is pending
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request ready while path beat pending");

	// a delivered beat is never shown again in the next cycle
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> !m_tvalid)
		else $error("path beat repeated");

	// the block is ready again right after the final beat
	a_end_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not ready after final path beat");

	// a stalled beat holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled path beat changed");

endmodule

bind shortest_path_relaxation spr_checker u_spr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
